[rtl/core/symmetric_fir_filter_assert.svh]
// assertion macros for the symmetric fir filter
`ifndef SYMMETRIC_FIR_FILTER_ASSERT_SVH
`define SYMMETRIC_FIR_FILTER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define SFIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define SFIR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/sfir_pkg.sv]
`default_nettype none

package sfir_pkg;

  localparam int TAPS_DEF      = 85;
  localparam int COEF_BITS_DEF = 16;
  localparam int SAMPLE_W      = 16;
  localparam int SLOT_W        = 6;
  localparam int SHIFT_W       = 5;
  localparam int APB_W         = 32;
  localparam int ADDR_W        = 3;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

  // register index, taken from paddr above the byte offset
  localparam logic [ADDR_W-3:0] REG_OUTPUT_SHIFT = 1'b0;

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic mid;
  } mac_ctl_t;

endpackage

`default_nettype wire

[rtl/core/sfir_delay.sv]
`default_nettype none

module sfir_delay #(
  parameter int TAPS = sfir_pkg::TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [$clog2(TAPS)-1:0]               wr_addr,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic [$clog2(TAPS)-1:0]               rd_addr_a,
  input  logic [$clog2(TAPS)-1:0]               rd_addr_b,
  output logic signed [sfir_pkg::SAMPLE_W-1:0]  rd_a,
  output logic signed [sfir_pkg::SAMPLE_W-1:0]  rd_b
);
  import sfir_pkg::*;

  logic [SAMPLE_W-1:0] mem [TAPS];
  logic [TAPS-1:0]     vld;
  logic [SAMPLE_W-1:0] raw_a;
  logic [SAMPLE_W-1:0] raw_b;
  logic                vld_a;
  logic                vld_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    raw_a <= mem[rd_addr_a];
    raw_b <= mem[rd_addr_b];
    vld_a <= vld[rd_addr_a];
    vld_b <= vld[rd_addr_b];
  end

  // unwritten slots read as zero
  assign rd_a = vld_a ? raw_a : '0;
  assign rd_b = vld_b ? raw_b : '0;

endmodule

`default_nettype wire

[rtl/core/sfir_mac.sv]
`default_nettype none

module sfir_mac #(
  parameter int COEF_BITS = sfir_pkg::COEF_BITS_DEF,
  parameter int ACC_W     = 42
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sfir_pkg::mac_ctl_t                    ctl,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0]  a,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0]  b,
  input  logic signed [COEF_BITS-1:0]           coef,
  output logic                                  busy,
  output logic signed [ACC_W-1:0]               acc
);
  import sfir_pkg::*;

  localparam int FOLD_W = SAMPLE_W + 1;
  localparam int PROD_W = FOLD_W + COEF_BITS;

  logic signed [FOLD_W-1:0]    fold_sum;
  logic signed [FOLD_W-1:0]    fold_q;
  logic signed [COEF_BITS-1:0] coef_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic                        v1;
  logic                        v2;

  // middle tap stands alone
  assign fold_sum = {a[SAMPLE_W-1], a} + (ctl.mid ? '0 : {b[SAMPLE_W-1], b});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    fold_q <= fold_sum;
    coef_q <= coef;
    prod_q <= fold_q * coef_q;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign busy = v1 | v2;

endmodule

`default_nettype wire

[rtl/core/sfir_scale.sv]
`default_nettype none

module sfir_scale #(
  parameter int ACC_W = 42
) (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic signed [ACC_W-1:0]               acc,
  input  logic [sfir_pkg::SHIFT_W-1:0]          shift,
  output logic signed [sfir_pkg::SAMPLE_W-1:0]  filtered,
  output logic                                  saturated
);
  import sfir_pkg::*;

  localparam int RND_W = ((ACC_W > 32) ? ACC_W : 32) + 1;
  localparam logic signed [RND_W-1:0] SMAX = RND_W'(2**(SAMPLE_W-1) - 1);
  localparam logic signed [RND_W-1:0] SMIN = -SMAX - RND_W'(1);

  logic signed [RND_W-1:0] bias;
  logic signed [RND_W-1:0] rnd;
  logic signed [RND_W-1:0] shifted;

  assign bias = (shift == '0) ? '0 : (RND_W'(1) << (shift - SHIFT_W'(1)));

  always_ff @(posedge clk) begin
    if (load) begin
      rnd <= {{(RND_W-ACC_W){acc[ACC_W-1]}}, acc} + bias;
    end
  end

  assign shifted = rnd >>> shift;

  always_comb begin
    saturated = 1'b0;
    filtered  = SAMPLE_W'(shifted);
    if (shifted > SMAX) begin
      saturated = 1'b1;
      filtered  = SAMPLE_W'(SMAX);
    end else if (shifted < SMIN) begin
      saturated = 1'b1;
      filtered  = SAMPLE_W'(SMIN);
    end
  end

endmodule

`default_nettype wire

[rtl/core/symmetric_fir_filter.sv]
// symmetric fir filter, odd length, 16-bit signed samples
// request channel: cmd_valid/cmd_ready with command, sample_in, coef_slot,
//   coef_value. command filter stores a sample and yields one result,
//   command coef writes one half-table coefficient and yields none
// result channel: res_valid/res_ready with filtered and saturated
// config: apb port, output_shift at byte address 0, reset value 15
// a filter request runs one shared fold-multiply-accumulate over the
//   (TAPS+1)/2 coefficients, one per cycle, then drains the read, fold,
//   multiply and accumulate stages and rounds
// the next request is taken the cycle after the result is loaded, even
//   while that result still waits; if the receiver stalls, a following
//   filter request finishes and then holds until the result register frees
// reset clears the delay line, the coefficient table, the pointer and
//   the result valid flag
`default_nettype none

module symmetric_fir_filter #(
  parameter int TAPS      = sfir_pkg::TAPS_DEF,
  parameter int COEF_BITS = sfir_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  logic                                  command,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [sfir_pkg::SLOT_W-1:0]           coef_slot,
  input  logic signed [sfir_pkg::SAMPLE_W-1:0]  coef_value,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output logic signed [sfir_pkg::SAMPLE_W-1:0]  filtered,
  output logic                                  saturated,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sfir_pkg::ADDR_W-1:0]           paddr,
  input  logic [sfir_pkg::APB_W-1:0]            pwdata,
  output logic [sfir_pkg::APB_W-1:0]            prdata,
  output logic                                  pready
);
  import sfir_pkg::*;

`include "symmetric_fir_filter_assert.svh"

  localparam int MID   = (TAPS - 1) / 2;
  localparam int PW    = $clog2(TAPS);
  localparam int CI_W  = $clog2(MID + 1);
  localparam int ACC_W = SAMPLE_W + 1 + COEF_BITS + CI_W + 1;

  state_t                      state;
  state_t                      state_next;
  logic [SHIFT_W-1:0]          output_shift;
  logic [PW-1:0]               wp;
  logic [PW-1:0]               a_ptr;
  logic [PW-1:0]               b_ptr;
  logic [CI_W-1:0]             k;
  logic                        rd_v;
  logic                        rd_mid;
  logic                        accept;
  logic                        filt_acc;
  logic                        coef_wr;
  logic                        emit;
  logic                        reg_wr;
  logic [COEF_BITS-1:0]        cmem [MID+1];
  logic [MID:0]                cvalid;
  logic [COEF_BITS-1:0]        coef_raw;
  logic                        cvld_q;
  logic signed [COEF_BITS-1:0] coef_rd;
  logic signed [SAMPLE_W-1:0]  dl_a;
  logic signed [SAMPLE_W-1:0]  dl_b;
  mac_ctl_t                    mac_ctl;
  logic                        mac_busy;
  logic signed [ACC_W-1:0]     acc;
  logic signed [SAMPLE_W-1:0]  sc_filtered;
  logic                        sc_saturated;

  // apb
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_OUTPUT_SHIFT);
  assign prdata = (paddr[ADDR_W-1:2] == REG_OUTPUT_SHIFT) ?
                  {{(APB_W-SHIFT_W){1'b0}}, output_shift} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_shift <= SHIFT_RESET;
    end else if (reg_wr) begin
      output_shift <= pwdata[SHIFT_W-1:0];
    end
  end

  // sequencer
  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign filt_acc  = accept && (command == CMD_FILTER);
  assign coef_wr   = accept && (command == CMD_COEF) && (int'(coef_slot) <= MID);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (filt_acc) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (k == CI_W'(MID)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v && !mac_busy) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_valid || res_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= PW'(TAPS - 1);
      k         <= '0;
      rd_v      <= 1'b0;
      rd_mid    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_v   <= (state == ST_RUN);
      rd_mid <= (k == CI_W'(MID));
      if (filt_acc) begin
        k <= '0;
      end else if (state == ST_RUN && k != CI_W'(MID)) begin
        k <= k + CI_W'(1);
      end
      if (state == ST_RUN && k == CI_W'(MID)) begin
        wp <= (wp == '0) ? PW'(TAPS - 1) : wp - PW'(1);
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // tap pointers walk inward from the newest and oldest samples
  always_ff @(posedge clk) begin
    if (filt_acc) begin
      a_ptr <= wp;
      b_ptr <= (wp == '0) ? PW'(TAPS - 1) : wp - PW'(1);
    end else if (state == ST_RUN) begin
      a_ptr <= (a_ptr == PW'(TAPS - 1)) ? '0 : a_ptr + PW'(1);
      b_ptr <= (b_ptr == '0) ? PW'(TAPS - 1) : b_ptr - PW'(1);
    end
    if (emit) begin
      filtered  <= sc_filtered;
      saturated <= sc_saturated;
    end
  end

  // coefficient table
  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
    end else if (coef_wr) begin
      cvalid[CI_W'(coef_slot)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      cmem[CI_W'(coef_slot)] <= COEF_BITS'($unsigned(coef_value));
    end
    coef_raw <= cmem[k];
    cvld_q   <= cvalid[k];
  end

  assign coef_rd = cvld_q ? coef_raw : '0;

  sfir_delay #(
    .TAPS (TAPS)
  ) u_delay (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (filt_acc),
    .wr_addr   (wp),
    .wr_data   (sample_in),
    .rd_addr_a (a_ptr),
    .rd_addr_b (b_ptr),
    .rd_a      (dl_a),
    .rd_b      (dl_b)
  );

  assign mac_ctl.clear = filt_acc;
  assign mac_ctl.valid = rd_v;
  assign mac_ctl.mid   = rd_mid;

  sfir_mac #(
    .COEF_BITS (COEF_BITS),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (dl_a),
    .b    (dl_b),
    .coef (coef_rd),
    .busy (mac_busy),
    .acc  (acc)
  );

  sfir_scale #(
    .ACC_W (ACC_W)
  ) u_scale (
    .clk       (clk),
    .load      (state == ST_ROUND),
    .acc       (acc),
    .shift     (output_shift),
    .filtered  (sc_filtered),
    .saturated (sc_saturated)
  );

  `SFIR_NEVER(a_wp_range, wp > PW'(TAPS - 1), "write pointer out of range")
  `SFIR_ASSERT(a_filter_starts, filt_acc |=> state == ST_RUN, "filter request did not start")
  `SFIR_ASSERT(a_run_ends, state == ST_RUN && k == CI_W'(MID) |=> state == ST_DRAIN, "run overran")
  `SFIR_ASSERT(a_emit_holds, res_valid && !res_ready |=> res_valid, "result overwritten")

endmodule

`default_nettype wire
